>>> src/mtep_pkg.sv
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int unsigned MAX_VLQ_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned VLQ_W = 28;

  typedef enum logic [2:0] {
    KIND_MESSAGE = 3'd0,
    KIND_META    = 3'd1,
    KIND_SYSEX   = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  localparam logic ERR_FORMAT = 1'b0;
  localparam logic ERR_TRUNC  = 1'b1;

  localparam logic [7:0] ST_SYSEX_F0 = 8'hF0;
  localparam logic [7:0] ST_SYSEX_F7 = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic       track_last;
    logic       is_data;
    logic [1:0] byte_len;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       status;
    logic [6:0]       data_first;
    logic [6:0]       data_second;
    logic [1:0]       message_length;
    logic [VLQ_W-1:0] payload_length;
    logic [VLQ_W-1:0] delta_ticks;
    logic [31:0]      absolute_tick;
    logic [7:0]       payload_byte;
    logic             event_end;
    logic             track_done;
    logic             error_code;
  } res_t;

  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    case (s) inside
      [8'hC0:8'hDF]: len = 2'd2;
      [8'h80:8'hEF]: len = 2'd3;
      8'hF1, 8'hF3: len = 2'd2;
      8'hF2: len = 2'd3;
      8'hF6, [8'hF8:8'hFE]: len = 2'd1;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

>>> src/mtep_front.sv
`timescale 1ns / 1ps

module mtep_front
  import mtep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       track_start_i,
  input  logic       track_last_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;
  item_t            new_item;

  assign in_ready_o = cnt_q != CntW'(QUEUE_DEPTH);
  assign q_valid_o  = cnt_q != '0;
  assign q_item_o   = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  // classify the byte on the way in
  always_comb begin
    new_item.data_byte   = data_byte_i;
    new_item.track_start = track_start_i;
    new_item.track_last  = track_last_i;
    new_item.is_data     = ~data_byte_i[7];
    new_item.byte_len    = msg_len(data_byte_i);
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(wr_q + 1'b1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(rd_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_item;
    end
  end

endmodule

>>> src/mtep_back.sv
`timescale 1ns / 1ps

module mtep_back
  import mtep_pkg::*;
#(
  parameter int unsigned MAX_VLQ_BYTES = MAX_VLQ_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA      = 4'd2,
    PH_META_TYPE = 4'd3,
    PH_META_LEN  = 4'd4,
    PH_SYSEX_LEN = 4'd5,
    PH_META_PAY  = 4'd6,
    PH_SYSEX_PAY = 4'd7,
    PH_DONE      = 4'd8,
    PH_ERROR     = 4'd9
  } phase_e;

  localparam logic [2:0] VcntMax = 3'(MAX_VLQ_BYTES);

  phase_e           phase_q, phase_d, ph;
  logic [7:0]       rs_q, rs_d, cur_q, cur_d;
  logic [VLQ_W-1:0] delta_q, delta_d, len_q, len_d;
  logic [2:0]       vcnt_q, vcnt_d;
  logic [31:0]      tick_q, tick_d;
  logic [6:0]       cap0_q, cap0_d, cap1_q, cap1_d;
  logic [1:0]       dcnt_q, dcnt_d;
  logic [1:0]       cur_len;
  logic             res_vld, err, err_code, meta, fin, done;
  logic             out_valid_q, fire;
  logic [7:0]       b;
  res_t             res_d, res_q;

  assign fire        = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o     = fire;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign b           = q_item_i.data_byte;

  always_comb begin
    ph      = q_item_i.track_start ? PH_DELTA : phase_q;
    phase_d = ph;
    rs_d    = rs_q;
    delta_d = delta_q;
    vcnt_d  = vcnt_q;
    tick_d  = tick_q;
    cur_d   = cur_q;
    len_d   = len_q;
    cap0_d  = cap0_q;
    cap1_d  = cap1_q;
    dcnt_d  = dcnt_q;
    if (q_item_i.track_start) begin
      rs_d    = '0;
      delta_d = '0;
      vcnt_d  = '0;
      tick_d  = '0;
      cur_d   = '0;
      len_d   = '0;
      cap0_d  = '0;
      cap1_d  = '0;
      dcnt_d  = '0;
    end
    res_vld  = 1'b0;
    res_d    = '0;
    err      = 1'b0;
    err_code = ERR_FORMAT;
    meta     = 1'b0;
    fin      = 1'b0;
    done     = 1'b0;
    cur_len  = '0;

    case (ph)
      PH_DELTA: begin
        if (vcnt_d == '0) begin
          delta_d = '0;
        end
        delta_d = {delta_d[VLQ_W-8:0], b[6:0]};
        vcnt_d  = 3'(vcnt_d + 3'd1);
        if (!b[7]) begin
          tick_d  = tick_d + {4'b0, delta_d};
          vcnt_d  = '0;
          phase_d = PH_STATUS;
        end else if (vcnt_d >= VcntMax) begin
          err = 1'b1;
        end
      end
      PH_STATUS: begin
        cap0_d = '0;
        cap1_d = '0;
        dcnt_d = '0;
        if (q_item_i.is_data) begin
          if (rs_d == '0) begin
            err = 1'b1;
          end else begin
            cur_d   = rs_d;
            cap0_d  = b[6:0];
            dcnt_d  = 2'd1;
            phase_d = (msg_len(rs_d) <= 2'd2) ? PH_DELTA : PH_DATA;
            res_vld = msg_len(rs_d) <= 2'd2;
          end
        end else if (b == ST_META) begin
          phase_d = PH_META_TYPE;
        end else if (b == ST_SYSEX_F0 || b == ST_SYSEX_F7) begin
          rs_d    = '0;
          cur_d   = b;
          len_d   = '0;
          vcnt_d  = '0;
          phase_d = PH_SYSEX_LEN;
        end else begin
          if (b <= 8'hEF) begin
            rs_d = b;
          end
          if (q_item_i.byte_len == 2'd0) begin
            err = 1'b1;
          end else begin
            cur_d   = b;
            res_vld = q_item_i.byte_len == 2'd1;
            phase_d = res_vld ? PH_DELTA : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (dcnt_d[0]) begin
          cap1_d = b[6:0];
        end else begin
          cap0_d = b[6:0];
        end
        dcnt_d = 2'(dcnt_d + 2'd1);
        if ({1'b0, dcnt_d} + 3'd1 >= {1'b0, msg_len(cur_d)}) begin
          res_vld = 1'b1;
          phase_d = PH_DELTA;
        end
      end
      PH_META_TYPE: begin
        cur_d   = b;
        len_d   = '0;
        vcnt_d  = '0;
        phase_d = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        meta   = ph == PH_META_LEN;
        len_d  = {len_d[VLQ_W-8:0], b[6:0]};
        vcnt_d = 3'(vcnt_d + 3'd1);
        if (!b[7]) begin
          vcnt_d               = '0;
          res_vld              = 1'b1;
          res_d.kind           = meta ? KIND_META : KIND_SYSEX;
          res_d.status         = cur_d;
          res_d.payload_length = len_d;
          if (len_d == '0) begin
            done            = meta && cur_d == META_EOT;
            res_d.event_end = 1'b1;
            res_d.track_done = done;
            phase_d         = done ? PH_DONE : PH_DELTA;
          end else begin
            phase_d = meta ? PH_META_PAY : PH_SYSEX_PAY;
          end
        end else if (vcnt_d >= VcntMax) begin
          err = 1'b1;
        end
      end
      PH_META_PAY, PH_SYSEX_PAY: begin
        meta               = ph == PH_META_PAY;
        len_d              = VLQ_W'(len_d - 1'b1);
        fin                = len_d == '0;
        done               = fin && meta && cur_d == META_EOT;
        res_vld            = 1'b1;
        res_d.kind         = KIND_PAYLOAD;
        res_d.status       = cur_d;
        res_d.payload_byte = b;
        res_d.event_end    = fin;
        res_d.track_done   = done;
        if (fin) begin
          phase_d = done ? PH_DONE : PH_DELTA;
        end
      end
      default: begin
      end
    endcase

    // channel or system message assembled from the captured bytes
    if (res_vld && (ph == PH_STATUS || ph == PH_DATA)) begin
      cur_len              = msg_len(cur_d);
      res_d.kind           = KIND_MESSAGE;
      res_d.status         = cur_d;
      res_d.data_first     = (cur_len >= 2'd2) ? cap0_d : '0;
      res_d.data_second    = (cur_len >= 2'd3) ? cap1_d : '0;
      res_d.message_length = cur_len;
      res_d.event_end      = 1'b1;
    end
    res_d.delta_ticks   = delta_d;
    res_d.absolute_tick = tick_d;

    if (!err && ph != PH_DONE && ph != PH_ERROR && q_item_i.track_last &&
        phase_d != PH_DONE && !(phase_d == PH_DELTA && vcnt_d == '0)) begin
      err = 1'b1;
      err_code = (phase_d == PH_STATUS || phase_d == PH_DATA ||
                  phase_d == PH_META_TYPE) ? ERR_TRUNC : ERR_FORMAT;
    end

    if (err) begin
      phase_d          = PH_ERROR;
      res_vld          = 1'b1;
      res_d            = '0;
      res_d.kind       = KIND_ERROR;
      res_d.error_code = err_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DELTA;
      rs_q        <= '0;
      delta_q     <= '0;
      vcnt_q      <= '0;
      tick_q      <= '0;
      cur_q       <= '0;
      len_q       <= '0;
      cap0_q      <= '0;
      cap1_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        rs_q    <= rs_d;
        delta_q <= delta_d;
        vcnt_q  <= vcnt_d;
        tick_q  <= tick_d;
        cur_q   <= cur_d;
        len_q   <= len_d;
        cap0_q  <= cap0_d;
        cap1_q  <= cap1_d;
        dcnt_q  <= dcnt_d;
      end
      if (fire && res_vld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_vld) begin
      res_q <= res_d;
    end
  end

endmodule

>>> src/midi_track_event_parser.sv
`timescale 1ns / 1ps

// channel  dir  handshake               payload
// in       in   in_valid_i/in_ready_o   data_byte_i, track_start_i, track_last_i
// out      out  out_valid_o/out_ready_i kind_o .. error_code_o (one result)
//
// One byte per cycle sustained while the output is not stalled; a result
// passes through the input queue, then the parser's output register, and is
// presented from that register.
// The parser updates its state for one byte a cycle, so that loop sets the rate.
// Reset clears the queue, parse state and output valid.
// A stalled output holds the parser; the two-entry queue keeps taking bytes
// until it fills.

module midi_track_event_parser
  import mtep_pkg::*;
#(
  parameter int unsigned MAX_VLQ_BYTES = MAX_VLQ_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        track_start_i,
  input  logic        track_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  status_o,
  output logic [6:0]  data_first_o,
  output logic [6:0]  data_second_o,
  output logic [1:0]  message_length_o,
  output logic [27:0] payload_length_o,
  output logic [27:0] delta_ticks_o,
  output logic [31:0] absolute_tick_o,
  output logic [7:0]  payload_byte_o,
  output logic        event_end_o,
  output logic        track_done_o,
  output logic        error_code_o
);

  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  mtep_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .track_start_i (track_start_i),
    .track_last_i  (track_last_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  mtep_back #(
    .MAX_VLQ_BYTES (MAX_VLQ_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign status_o         = res.status;
  assign data_first_o     = res.data_first;
  assign data_second_o    = res.data_second;
  assign message_length_o = res.message_length;
  assign payload_length_o = res.payload_length;
  assign delta_ticks_o    = res.delta_ticks;
  assign absolute_tick_o  = res.absolute_tick;
  assign payload_byte_o   = res.payload_byte;
  assign event_end_o      = res.event_end;
  assign track_done_o     = res.track_done;
  assign error_code_o     = res.error_code;

endmodule
